FILE: rtl/bitmap_font_glyph_quad_layout_top_defines.svh
// ---------------------------------------------------------------------------
// Glyph quad layout: assertion macros
// Shared assertion wrappers for the layout engine modules.
// ---------------------------------------------------------------------------
`ifndef BITMAP_FONT_GLYPH_QUAD_LAYOUT_TOP_DEFINES_SVH
`define BITMAP_FONT_GLYPH_QUAD_LAYOUT_TOP_DEFINES_SVH

// same-cycle implication
`define BFGQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BFGQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bfgq_pkg.sv
// ---------------------------------------------------------------------------
// Glyph quad layout package
// Codes, entry layouts and the controller/datapath interface structs.
// ---------------------------------------------------------------------------
package bfgq_pkg;

  // function codes of an input word
  localparam logic [2:0] FN_LOAD_GLYPH  = 3'd0;
  localparam logic [2:0] FN_LOAD_PAGE   = 3'd1;
  localparam logic [2:0] FN_SET_UNKNOWN = 3'd2;
  localparam logic [2:0] FN_SET_PEN     = 3'd3;
  localparam logic [2:0] FN_RENDER      = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_RECT_LEFT   = 3'd0;
  localparam logic [2:0] REG_RECT_TOP    = 3'd1;
  localparam logic [2:0] REG_RECT_WIDTH  = 3'd2;
  localparam logic [2:0] REG_RECT_HEIGHT = 3'd3;
  localparam logic [2:0] REG_LINE_HEIGHT = 3'd4;
  localparam logic [2:0] REG_TEXT_COLOR  = 3'd5;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DROP = 2'd1,
    ST_PAGE = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_PAGE,
    S_WRAP,
    S_CLIP,
    S_UV_GO,
    S_UV,
    S_EMIT
  } state_t;

  // glyph source: atlas position, size, page
  typedef struct packed {
    logic [7:0]  page;
    logic [12:0] h;
    logic [12:0] w;
    logic [14:0] y;
    logic [14:0] x;
  } src_t;

  // glyph placement (two's complement fields)
  typedef struct packed {
    logic [9:0] adv;
    logic [9:0] oy;
    logic [9:0] ox;
  } plc_t;

  typedef struct packed {
    logic [20:0] code;
    src_t        src;
    plc_t        plc;
  } glyph_t;

  typedef struct packed {
    logic [12:0] h;
    logic [12:0] w;
    logic [14:0] y;
    logic [14:0] x;
  } page_t;

  typedef struct packed {
    logic [31:0] color;
    logic [7:0]  page;
    logic [15:0] vb;
    logic [15:0] ur;
    logic [15:0] vt;
    logic [15:0] ul;
    logic [16:0] qb;
    logic [16:0] qr;
    logic [16:0] qt;
    logic [16:0] ql;
    status_t     status;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic scan;
    logic page_rd;
    logic wrap;
    logic clip;
    logic div_start;
    logic div_store;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_render;
    logic scan_done;
    logic page_ok;
    logic wrap_drop;
    logic clip_drop;
    logic div_done;
    logic uv_last;
    logic out_free;
  } stat_t;

  // clamp to the 17-bit signed range
  function automatic logic [16:0] sat17(input logic signed [19:0] v);
    logic [16:0] r;
    if (v < -20'sd65536) r = 17'h10000;
    else if (v > 20'sd65535) r = 17'h0FFFF;
    else r = v[16:0];
    return r;
  endfunction

endpackage

FILE: rtl/bitmap_font_glyph_quad_layout_top.sv
// ---------------------------------------------------------------------------
// Bitmap font glyph quad layout
// Top level: controller, datapath and stream ports.
// ---------------------------------------------------------------------------
// Each input word yields exactly one result word. Loads, pen sets and unused
// function codes pass through the accept, execute and emit steps. A render
// takes the accept and execute steps, a linear scan of the glyph memory (one
// entry per cycle, registered read), the page read, wrap and clip steps, then
// the four texture coordinates in turn in the shared one-bit-per-cycle
// divider (a coordinate that saturates needs no division), then the emit step.
// A page error or a dropped glyph skips the divider. Words are handled one
// at a time; a finished word waits in the output register while the next
// one is taken in, and the emit step stalls while that register is full.
`include "bitmap_font_glyph_quad_layout_top_defines.svh"

module bitmap_font_glyph_quad_layout_top #(
  parameter int GLYPH_ENTRIES = 256,
  parameter int PAGE_ENTRIES  = 4,
  parameter int UV_FRAC_BITS  = 15
) (
  input  logic         clk,
  input  logic         rst,
  // configuration write channel
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // char_code, src_x, src_y, size_w, size_h, offset_x, offset_y, advance, page_ref
  input  logic [119:0] s_tdata,
  // func
  input  logic [2:0]   s_tuser,
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // quad_left, quad_top, quad_right, quad_bottom, u_left, v_top, u_right,
  // v_bottom, page_index, quad_color
  output logic [175:0] m_tdata,
  // status
  output logic [1:0]   m_tuser
);

  bfgq_pkg::cmd_t  cmd;
  bfgq_pkg::stat_t stat;

  bfgq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bfgq_dp #(
    .GLYPH_ENTRIES (GLYPH_ENTRIES),
    .PAGE_ENTRIES  (PAGE_ENTRIES),
    .UV_FRAC_BITS  (UV_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

FILE: rtl/bfgq_div.sv
// ---------------------------------------------------------------------------
// Texture coordinate divider
// (texel << FRAC) / size, saturated at 1.0, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module bfgq_div #(
  parameter int FRAC = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [16:0] texel,
  input  logic [12:0] size,
  output logic        done,
  output logic [15:0] quot
);

  localparam int QW = FRAC + 1;
  localparam int CW = $clog2(FRAC + 1);

  logic [13:0]    rem;
  logic [QW-1:0]  q;
  logic [CW-1:0]  cnt;
  logic           busy;
  logic [13:0]    r2;
  logic           ge;
  logic [QW+15:0] q_ext;

  // one restoring step; remainder stays below size
  assign r2    = {rem[12:0], 1'b0};
  assign ge    = r2 >= {1'b0, size};
  assign q_ext = {16'b0, q};
  assign quot  = q_ext[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (size == 13'd0 || texel >= {4'b0, size}) begin
          // quotient at or above 1.0
          q    <= {1'b1, {FRAC{1'b0}}};
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          rem  <= {1'b0, texel[12:0]};
          q    <= '0;
          cnt  <= CW'(FRAC);
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= ge ? (r2 - {1'b0, size}) : r2;
        q   <= {q[QW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/bfgq_ctrl.sv
// ---------------------------------------------------------------------------
// Glyph quad layout controller
// Sequences load, glyph scan, page check, wrap, clip, UV and emit steps.
// ---------------------------------------------------------------------------
`include "bitmap_font_glyph_quad_layout_top_defines.svh"

module bfgq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  bfgq_pkg::stat_t stat,
  output bfgq_pkg::cmd_t  cmd
);

  bfgq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= bfgq_pkg::S_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bfgq_pkg::S_IDLE: if (in_valid) state_next = bfgq_pkg::S_EXEC;
      bfgq_pkg::S_EXEC: begin
        state_next = stat.is_render ? bfgq_pkg::S_SCAN : bfgq_pkg::S_EMIT;
      end
      bfgq_pkg::S_SCAN: if (stat.scan_done) state_next = bfgq_pkg::S_PAGE;
      bfgq_pkg::S_PAGE: begin
        state_next = stat.page_ok ? bfgq_pkg::S_WRAP : bfgq_pkg::S_EMIT;
      end
      bfgq_pkg::S_WRAP: begin
        state_next = stat.wrap_drop ? bfgq_pkg::S_EMIT : bfgq_pkg::S_CLIP;
      end
      bfgq_pkg::S_CLIP: begin
        state_next = stat.clip_drop ? bfgq_pkg::S_EMIT : bfgq_pkg::S_UV_GO;
      end
      bfgq_pkg::S_UV_GO: state_next = bfgq_pkg::S_UV;
      bfgq_pkg::S_UV: begin
        if (stat.div_done) begin
          state_next = stat.uv_last ? bfgq_pkg::S_EMIT : bfgq_pkg::S_UV_GO;
        end
      end
      bfgq_pkg::S_EMIT: if (stat.out_free) state_next = bfgq_pkg::S_IDLE;
      default: state_next = bfgq_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state)
      bfgq_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      bfgq_pkg::S_EXEC:  cmd.exec      = 1'b1;
      bfgq_pkg::S_SCAN:  cmd.scan      = 1'b1;
      bfgq_pkg::S_PAGE:  cmd.page_rd   = 1'b1;
      bfgq_pkg::S_WRAP:  cmd.wrap      = 1'b1;
      bfgq_pkg::S_CLIP:  cmd.clip      = 1'b1;
      bfgq_pkg::S_UV_GO: cmd.div_start = 1'b1;
      bfgq_pkg::S_UV:    cmd.div_store = stat.div_done;
      bfgq_pkg::S_EMIT:  cmd.emit      = stat.out_free;
      default: ;
    endcase
  end

  `BFGQ_ASSERT_NOW(a_emit_free, cmd.emit, stat.out_free, "emit into a full output register")
  `BFGQ_ASSERT_NEXT(a_start_waits, cmd.div_start, state == bfgq_pkg::S_UV, "divider start not followed by wait")
  `BFGQ_ASSERT_NEXT(a_accept_exec, cmd.accept, state == bfgq_pkg::S_EXEC, "accepted word not executed")

endmodule

FILE: rtl/bfgq_dp.sv
// ---------------------------------------------------------------------------
// Glyph quad layout datapath
// Configuration, glyph and page memories, pen, geometry, UV and result.
// ---------------------------------------------------------------------------
`include "bitmap_font_glyph_quad_layout_top_defines.svh"

module bfgq_dp #(
  parameter int GLYPH_ENTRIES = 256,
  parameter int PAGE_ENTRIES  = 4,
  parameter int UV_FRAC_BITS  = 15
) (
  input  logic            clk,
  input  logic            rst,
  // configuration
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  // input word payload
  input  logic [119:0]    s_tdata,
  input  logic [2:0]      s_tuser,
  // result word
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [175:0]    m_tdata,
  output logic [1:0]      m_tuser,
  // control
  input  bfgq_pkg::cmd_t  cmd,
  output bfgq_pkg::stat_t stat
);

  localparam int GA_W = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
  localparam int GC_W = $clog2(GLYPH_ENTRIES + 1);
  localparam int PA_W = (PAGE_ENTRIES > 1) ? $clog2(PAGE_ENTRIES) : 1;
  localparam int PC_W = $clog2(PAGE_ENTRIES + 1);

  // configuration registers
  logic [14:0] rect_left, rect_top, rect_width, rect_height;
  logic [11:0] line_height;
  logic [31:0] text_color;

  // latched input word
  logic [2:0]       in_func;
  logic [20:0]      in_code;
  bfgq_pkg::src_t   in_src;
  bfgq_pkg::plc_t   in_plc;

  // tables
  bfgq_pkg::glyph_t gmem [GLYPH_ENTRIES];
  bfgq_pkg::page_t  pmem [PAGE_ENTRIES];
  bfgq_pkg::glyph_t g_rd;
  bfgq_pkg::page_t  pg_rd;
  logic [GC_W-1:0]  glyph_count;
  logic [PC_W-1:0]  page_count;
  bfgq_pkg::src_t   fb_src;
  bfgq_pkg::plc_t   fb_plc;

  // scan
  logic [GC_W-1:0]  scan_addr;
  logic             scan_pend;
  logic             hit;
  bfgq_pkg::src_t   sel_src;
  bfgq_pkg::plc_t   sel_plc;

  // pen and result
  logic [16:0]      pen_x, pen_y;
  bfgq_pkg::res_t   res;
  logic [1:0]       uv_k;

  // arithmetic
  logic signed [19:0] px_end, lim_x, py_end, lim_y, left_px, top_px;
  logic               overrun, at_left;
  logic [15:0]        tl, tt;
  logic [16:0]        tr, tb, div_texel;
  logic [12:0]        div_size;
  logic               div_done;
  logic [15:0]        div_quot;
  logic               glyph_full, page_full;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rect_left   <= '0;
      rect_top    <= '0;
      rect_width  <= '0;
      rect_height <= '0;
      line_height <= '0;
      text_color  <= 32'hFFFF_FFFF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bfgq_pkg::REG_RECT_LEFT:   rect_left   <= cfg_data[14:0];
        bfgq_pkg::REG_RECT_TOP:    rect_top    <= cfg_data[14:0];
        bfgq_pkg::REG_RECT_WIDTH:  rect_width  <= cfg_data[14:0];
        bfgq_pkg::REG_RECT_HEIGHT: rect_height <= cfg_data[14:0];
        bfgq_pkg::REG_LINE_HEIGHT: line_height <= cfg_data[11:0];
        bfgq_pkg::REG_TEXT_COLOR:  text_color  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_func     <= s_tuser;
      in_code     <= s_tdata[20:0];
      in_src.x    <= s_tdata[35:21];
      in_src.y    <= s_tdata[50:36];
      in_src.w    <= s_tdata[63:51];
      in_src.h    <= s_tdata[76:64];
      in_plc.ox   <= s_tdata[86:77];
      in_plc.oy   <= s_tdata[96:87];
      in_plc.adv  <= s_tdata[106:97];
      in_src.page <= s_tdata[114:107];
    end
  end

  assign glyph_full = glyph_count >= GC_W'(GLYPH_ENTRIES);
  assign page_full  = page_count >= PC_W'(PAGE_ENTRIES);

  // glyph memory
  always_ff @(posedge clk) begin
    if (cmd.exec && in_func == bfgq_pkg::FN_LOAD_GLYPH && !glyph_full) begin
      gmem[glyph_count[GA_W-1:0]] <= '{code: in_code, src: in_src, plc: in_plc};
    end
    g_rd <= gmem[scan_addr[GA_W-1:0]];
  end

  // page memory
  always_ff @(posedge clk) begin
    if (cmd.exec && in_func == bfgq_pkg::FN_LOAD_PAGE && !page_full) begin
      pmem[page_count[PA_W-1:0]] <= '{h: in_src.h, w: in_src.w, y: in_src.y, x: in_src.x};
    end
    if (cmd.page_rd) pg_rd <= pmem[sel_src.page[PA_W-1:0]];
  end

  // scan: one entry a cycle, compare on registered read
  assign hit = scan_pend && (g_rd.code == in_code);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      scan_pend <= 1'b0;
    end else if (cmd.accept) begin
      scan_addr <= '0;
      scan_pend <= 1'b0;
    end else if (cmd.scan) begin
      scan_pend <= scan_addr < glyph_count;
      if (scan_addr < glyph_count) scan_addr <= scan_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sel_src <= fb_src;
      sel_plc <= fb_plc;
    end else if (cmd.scan && hit) begin
      sel_src <= g_rd.src;
      sel_plc <= g_rd.plc;
    end
  end

  // wrap and clip checks
  assign px_end  = {{3{pen_x[16]}}, pen_x} + {7'b0, sel_src.w};
  assign lim_x   = {4'b0, {1'b0, rect_left} + {1'b0, rect_width}};
  assign overrun = px_end > lim_x;
  assign at_left = pen_x == {2'b0, rect_left};
  assign py_end  = {{3{pen_y[16]}}, pen_y} + {7'b0, sel_src.h}
                   + {{10{sel_plc.oy[9]}}, sel_plc.oy};
  assign lim_y   = {4'b0, {1'b0, rect_top} + {1'b0, rect_height}};
  assign left_px = {{10{sel_plc.ox[9]}}, sel_plc.ox} + {{3{pen_x[16]}}, pen_x};
  assign top_px  = {{10{sel_plc.oy[9]}}, sel_plc.oy} + {{3{pen_y[16]}}, pen_y};

  // texel coordinates in the atlas
  assign tl = {1'b0, pg_rd.x} + {1'b0, sel_src.x};
  assign tt = {1'b0, pg_rd.y} + {1'b0, sel_src.y};
  assign tr = {1'b0, tl} + {4'b0, sel_src.w};
  assign tb = {1'b0, tt} + {4'b0, sel_src.h};

  always_comb begin
    unique case (uv_k)
      2'd0: div_texel = {1'b0, tl};
      2'd1: div_texel = {1'b0, tt};
      2'd2: div_texel = tr;
      2'd3: div_texel = tb;
      default: div_texel = tr;
    endcase
    div_size = uv_k[0] ? pg_rd.h : pg_rd.w;
  end

  bfgq_div #(.FRAC(UV_FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .texel (div_texel),
    .size  (div_size),
    .done  (div_done),
    .quot  (div_quot)
  );

  // state updates and result assembly
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_count <= '0;
      page_count  <= '0;
      fb_src      <= '0;
      fb_plc      <= '0;
      pen_x       <= '0;
      pen_y       <= '0;
      uv_k        <= '0;
    end else begin
      if (cmd.accept) begin
        res  <= '0;
        uv_k <= '0;
      end
      if (cmd.exec) begin
        priority if (in_func == bfgq_pkg::FN_LOAD_GLYPH) begin
          if (glyph_full) res.status <= bfgq_pkg::ST_FULL;
          else glyph_count <= glyph_count + 1'b1;
        end else if (in_func == bfgq_pkg::FN_LOAD_PAGE) begin
          if (page_full) res.status <= bfgq_pkg::ST_FULL;
          else page_count <= page_count + 1'b1;
        end else if (in_func == bfgq_pkg::FN_SET_UNKNOWN) begin
          fb_src <= in_src;
          fb_plc <= in_plc;
        end else if (in_func == bfgq_pkg::FN_SET_PEN) begin
          pen_x <= {2'b0, in_src.x};
          pen_y <= {2'b0, in_src.y};
        end else begin
        end
      end
      if (cmd.page_rd && !stat.page_ok) begin
        res.page   <= sel_src.page;
        res.status <= bfgq_pkg::ST_PAGE;
      end
      if (cmd.wrap) begin
        if (overrun && at_left) begin
          res.status <= bfgq_pkg::ST_DROP;
        end else if (overrun) begin
          pen_x <= {2'b0, rect_left};
          pen_y <= bfgq_pkg::sat17({{3{pen_y[16]}}, pen_y} + {8'b0, line_height});
        end
      end
      if (cmd.clip) begin
        if (stat.clip_drop) begin
          res.status <= bfgq_pkg::ST_DROP;
        end else begin
          res.ql    <= bfgq_pkg::sat17(left_px);
          res.qt    <= bfgq_pkg::sat17(top_px);
          res.qr    <= bfgq_pkg::sat17(left_px + {7'b0, sel_src.w});
          res.qb    <= bfgq_pkg::sat17(top_px + {7'b0, sel_src.h});
          res.page  <= sel_src.page;
          res.color <= text_color;
          pen_x     <= bfgq_pkg::sat17({{3{pen_x[16]}}, pen_x}
                                       + {{10{sel_plc.adv[9]}}, sel_plc.adv});
        end
      end
      if (cmd.div_store) begin
        unique case (uv_k)
          2'd0: res.ul <= div_quot;
          2'd1: res.vt <= div_quot;
          2'd2: res.ur <= div_quot;
          2'd3: res.vb <= div_quot;
          default: ;
        endcase
        uv_k <= uv_k + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {4'b0, res.color, res.page, res.vb, res.ur, res.vt, res.ul,
                  res.qb, res.qr, res.qt, res.ql};
      m_tuser <= res.status;
    end
  end

  // status to controller
  always_comb begin
    stat.is_render = in_func == bfgq_pkg::FN_RENDER;
    stat.scan_done = hit || (!scan_pend && scan_addr >= glyph_count);
    stat.page_ok   = {{PC_W{1'b0}}, sel_src.page} < {8'b0, page_count};
    stat.wrap_drop = overrun && at_left;
    stat.clip_drop = py_end > lim_y;
    stat.div_done  = div_done;
    stat.uv_last   = uv_k == 2'd3;
    stat.out_free  = !m_tvalid || m_tready;
  end

  `BFGQ_ASSERT_NOW(a_glyph_count, 1'b1, glyph_count <= GC_W'(GLYPH_ENTRIES), "glyph count past table")
  `BFGQ_ASSERT_NOW(a_page_count, 1'b1, page_count <= PC_W'(PAGE_ENTRIES), "page count past table")
  `BFGQ_ASSERT_NEXT(a_emit_valid, cmd.emit, m_tvalid, "emitted word not presented")

endmodule

FILE: sim/tb_top.sv
// ---------------------------------------------------------------------------
// Glyph quad layout testbench
// Drives load, pen and render words through the layout engine with random
// stream gaps and checks every result word against a cycle-free model or a typed row.
// ---------------------------------------------------------------------------
module tb_top;

  // function codes with no operation
  localparam logic [2:0] FN_RSVD_FIRST = 3'd5;
  localparam logic [2:0] FN_RSVD_LAST  = 3'd7;

  typedef struct packed {
    logic [2:0]  func;
    logic [20:0] code;
    logic [14:0] sx;
    logic [14:0] sy;
    logic [12:0] sw;
    logic [12:0] sh;
    logic [9:0]  ox;
    logic [9:0]  oy;
    logic [9:0]  adv;
    logic [7:0]  pref;
  } word_t;

  // directed row: config write or stimulus word, optionally with a typed result
  typedef struct {
    bit               is_cfg;
    logic [2:0]       idx;
    logic [31:0]      cval;
    word_t            w;
    bit               typed;
    bfgq_pkg::res_t   res;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [119:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [175:0] m_tdata;
  logic [1:0]   m_tuser;

  bitmap_font_glyph_quad_layout_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model state
  logic [20:0]      glyph_code_mem[256];
  bfgq_pkg::src_t   glyph_src_mem[256];
  bfgq_pkg::plc_t   glyph_plc_mem[256];
  int               glyph_cnt = 0;
  bfgq_pkg::page_t  page_mem[4];
  int               page_cnt = 0;
  bfgq_pkg::src_t   unk_src = '0;
  bfgq_pkg::plc_t   unk_plc = '0;
  longint           pen_x = 0, pen_y = 0;
  longint           r_left = 0, r_top = 0, r_width = 0, r_height = 0, r_line = 0;
  logic [31:0]      r_color = 32'hFFFF_FFFF;

  bfgq_pkg::res_t pending_quads[$];
  row_t           directed_rows[$];
  int             errors = 0;
  int             quads_seen = 0;

  function automatic longint clamp17(longint v);
    if (v < -65536) return -65536;
    if (v > 65535) return 65535;
    return v;
  endfunction

  function automatic logic [15:0] texcoord(longint texel, longint size);
    longint q;
    if (size == 0) return 16'h8000;
    q = (texel << 15) / size;
    if (q > 32768) q = 32768;
    return q[15:0];
  endfunction

  function automatic void apply_cfg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      bfgq_pkg::REG_RECT_LEFT:   r_left = longint'(v[14:0]);
      bfgq_pkg::REG_RECT_TOP:    r_top = longint'(v[14:0]);
      bfgq_pkg::REG_RECT_WIDTH:  r_width = longint'(v[14:0]);
      bfgq_pkg::REG_RECT_HEIGHT: r_height = longint'(v[14:0]);
      bfgq_pkg::REG_LINE_HEIGHT: r_line = longint'(v[11:0]);
      bfgq_pkg::REG_TEXT_COLOR:  r_color = v;
      default: ;
    endcase
  endfunction

  // advance the model by one word and return the result it produces
  function automatic bfgq_pkg::res_t layout_glyph(word_t w);
    bfgq_pkg::res_t  r;
    bfgq_pkg::src_t  s, ws;
    bfgq_pkg::plc_t  p, wp;
    int              pidx;
    longint          gw, gh, ox, oy, adv, tl, tt, lpx, tpx;
    bfgq_pkg::page_t pg;
    r = '0;
    ws = {w.pref, w.sh, w.sw, w.sy, w.sx};
    wp = {w.adv, w.oy, w.ox};
    case (w.func)
      bfgq_pkg::FN_LOAD_GLYPH: begin
        if (glyph_cnt >= 256) r.status = bfgq_pkg::ST_FULL;
        else begin
          glyph_code_mem[glyph_cnt] = w.code;
          glyph_src_mem[glyph_cnt] = ws;
          glyph_plc_mem[glyph_cnt] = wp;
          glyph_cnt++;
        end
      end
      bfgq_pkg::FN_LOAD_PAGE: begin
        if (page_cnt >= 4) r.status = bfgq_pkg::ST_FULL;
        else begin
          page_mem[page_cnt] = {w.sh, w.sw, w.sy, w.sx};
          page_cnt++;
        end
      end
      bfgq_pkg::FN_SET_UNKNOWN: begin
        unk_src = ws;
        unk_plc = wp;
      end
      bfgq_pkg::FN_SET_PEN: begin
        pen_x = longint'(w.sx);
        pen_y = longint'(w.sy);
      end
      bfgq_pkg::FN_RENDER: begin
        s = unk_src;
        p = unk_plc;
        for (int i = 0; i < glyph_cnt; i++) begin
          if (glyph_code_mem[i] == w.code) begin
            s = glyph_src_mem[i];
            p = glyph_plc_mem[i];
            break;
          end
        end
        pidx = int'(s.page);
        if (pidx >= page_cnt) begin
          r.page = s.page;
          r.status = bfgq_pkg::ST_PAGE;
          return r;
        end
        pg = page_mem[pidx];
        gw = longint'(s.w);
        gh = longint'(s.h);
        ox = longint'($signed(p.ox));
        oy = longint'($signed(p.oy));
        adv = longint'($signed(p.adv));
        if (pen_x + gw > r_left + r_width) begin
          // glyph too wide for an empty line
          if (pen_x == r_left) begin
            r.status = bfgq_pkg::ST_DROP;
            return r;
          end
          pen_x = r_left;
          pen_y = clamp17(pen_y + r_line);
        end
        // below the bottom edge: drop, but keep the wrap
        if (pen_y + gh + oy > r_top + r_height) begin
          r.status = bfgq_pkg::ST_DROP;
          return r;
        end
        tl = longint'(pg.x) + longint'(s.x);
        tt = longint'(pg.y) + longint'(s.y);
        lpx = ox + pen_x;
        tpx = oy + pen_y;
        r.ql = 17'(clamp17(lpx));
        r.qt = 17'(clamp17(tpx));
        r.qr = 17'(clamp17(lpx + gw));
        r.qb = 17'(clamp17(tpx + gh));
        r.ul = texcoord(tl, longint'(pg.w));
        r.vt = texcoord(tt, longint'(pg.h));
        r.ur = texcoord(tl + gw, longint'(pg.w));
        r.vb = texcoord(tt + gh, longint'(pg.h));
        r.page = s.page;
        r.color = r_color;
        pen_x = clamp17(pen_x + adv);
      end
      default: ;
    endcase
    return r;
  endfunction

  // random word; most renders hit a small pool of loaded codes
  function automatic word_t rand_word();
    word_t w;
    int    sel;
    sel = $urandom_range(0, 99);
    w.code = ($urandom_range(0, 9) == 0) ? 21'($urandom_range(0, 1114111))
                                         : 21'($urandom_range(0, 40));
    w.sx = 15'($urandom_range(0, 32767));
    w.sy = 15'($urandom_range(0, 32767));
    w.sw = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(0, 4096))
                                       : 13'($urandom_range(1, 48));
    w.sh = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(0, 4096))
                                       : 13'($urandom_range(1, 48));
    w.ox = ($urandom_range(0, 5) == 0) ? 10'($urandom) : 10'($urandom_range(0, 8) - 4);
    w.oy = ($urandom_range(0, 5) == 0) ? 10'($urandom) : 10'($urandom_range(0, 8) - 4);
    w.adv = ($urandom_range(0, 5) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40));
    w.pref = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
    if (sel < 50) w.func = bfgq_pkg::FN_RENDER;
    else if (sel < 66) w.func = bfgq_pkg::FN_LOAD_GLYPH;
    else if (sel < 69) begin
      w.func = bfgq_pkg::FN_LOAD_PAGE;
      if ($urandom_range(0, 3) != 0) begin
        w.sw = 13'($urandom_range(256, 4096));
        w.sh = 13'($urandom_range(256, 4096));
      end
    end else if (sel < 73) w.func = bfgq_pkg::FN_SET_UNKNOWN;
    else if (sel < 96) begin
      w.func = bfgq_pkg::FN_SET_PEN;
      // mostly inside the rectangle so that glyphs get drawn
      if ($urandom_range(0, 4) != 0) begin
        w.sx = 15'(r_left + $urandom_range(0, r_width));
        w.sy = 15'(r_top + $urandom_range(0, r_height / 2));
      end
    end else w.func = 3'($urandom_range(FN_RSVD_FIRST, FN_RSVD_LAST));
    return w;
  endfunction

  function automatic word_t mk(logic [2:0] f, logic [20:0] c, int x, int y, int ww, int hh,
                               int ox, int oy, int adv, int pref);
    word_t w;
    w = {f, c, 15'(x), 15'(y), 13'(ww), 13'(hh), 10'(ox), 10'(oy), 10'(adv), 8'(pref)};
    return w;
  endfunction

  function automatic void add_word(word_t w, bit typed = 1'b0,
                                   bfgq_pkg::status_t st = bfgq_pkg::ST_OK, int pg = 0);
    row_t rw;
    rw.is_cfg = 1'b0;
    rw.w = w;
    rw.typed = typed;
    rw.res = '0;
    rw.res.status = st;
    rw.res.page = 8'(pg);
    directed_rows.insert(directed_rows.size(), rw);
  endfunction

  function automatic void add_cfg(logic [2:0] idx, logic [31:0] v);
    row_t rw;
    rw = '{default: '0};
    rw.is_cfg = 1'b1;
    rw.idx = idx;
    rw.cval = v;
    directed_rows.insert(directed_rows.size(), rw);
  endfunction

  task automatic wait_idle();
    while (pending_quads.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_cfg(idx, v);
  endtask

  task automatic write_all(int l, int t, int wd, int ht, int lh, logic [31:0] col);
    wait_idle();
    write_reg(bfgq_pkg::REG_RECT_LEFT, 32'(l));
    write_reg(bfgq_pkg::REG_RECT_TOP, 32'(t));
    write_reg(bfgq_pkg::REG_RECT_WIDTH, 32'(wd));
    write_reg(bfgq_pkg::REG_RECT_HEIGHT, 32'(ht));
    write_reg(bfgq_pkg::REG_LINE_HEIGHT, 32'(lh));
    write_reg(bfgq_pkg::REG_TEXT_COLOR, col);
  endtask

  // offer one word; valid stays high across back-to-back words
  task automatic send_word(word_t w, bit typed, bfgq_pkg::res_t typed_res);
    int             gap;
    bfgq_pkg::res_t r;
    gap = $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= w.func;
    s_tdata <= {5'b0, w.pref, w.adv, w.oy, w.ox, w.sh, w.sw, w.sy, w.sx, w.code};
    do @(posedge clk); while (!s_tready);
    r = layout_glyph(w);
    pending_quads.insert(pending_quads.size(), typed ? typed_res : r);
  endtask

  task automatic run_phase(int n);
    for (int i = 0; i < n; i++) send_word(rand_word(), 1'b0, '0);
    s_tvalid <= 1'b0;
  endtask

  // stimulus and phase sequencing
  initial begin
    row_t rw;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    add_word(mk(bfgq_pkg::FN_RENDER, 21'h10FFFF, 0, 0, 0, 0, 0, 0, 0, 0), 1,
             bfgq_pkg::ST_PAGE, 0);
    add_word(mk(FN_RSVD_FIRST, 21'h1FFFFF, 32767, 32767, 8191, 8191, -1, -1, -1, 255), 1);
    add_word(mk(FN_RSVD_LAST, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1);
    add_word(mk(bfgq_pkg::FN_LOAD_PAGE, 0, 32767, 32767, 4096, 4096, 0, 0, 0, 0), 1);
    add_word(mk(bfgq_pkg::FN_LOAD_GLYPH, 21'h10FFFF, 0, 0, 4096, 4096, -512, 511, 511, 0),
             1);
    // empty rectangle, pen at its left edge: glyph cannot fit
    add_word(mk(bfgq_pkg::FN_RENDER, 21'h10FFFF, 0, 0, 0, 0, 0, 0, 0, 0), 1,
             bfgq_pkg::ST_DROP);
    add_cfg(bfgq_pkg::REG_RECT_WIDTH, 32767);
    add_cfg(bfgq_pkg::REG_RECT_HEIGHT, 32767);
    add_word(mk(bfgq_pkg::FN_RENDER, 21'h10FFFF, 0, 0, 0, 0, 0, 0, 0, 0));
    add_word(mk(bfgq_pkg::FN_SET_UNKNOWN, 21'h1FFFFF, 1, 2, 0, 0, 511, -512, -512, 3), 1);
    // fallback refers to a page not yet loaded
    add_word(mk(bfgq_pkg::FN_RENDER, 1234, 0, 0, 0, 0, 0, 0, 0, 0), 1,
             bfgq_pkg::ST_PAGE, 3);
    add_word(mk(bfgq_pkg::FN_LOAD_PAGE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1);
    add_word(mk(bfgq_pkg::FN_LOAD_PAGE, 0, 100, 200, 1, 4096, 0, 0, 0, 0), 1);
    add_word(mk(bfgq_pkg::FN_LOAD_PAGE, 0, 5, 7, 0, 0, 0, 0, 0, 0), 1);
    add_word(mk(bfgq_pkg::FN_LOAD_PAGE, 0, 1, 1, 64, 64, 0, 0, 0, 0), 1,
             bfgq_pkg::ST_FULL);
    add_word(mk(bfgq_pkg::FN_RENDER, 1234, 0, 0, 0, 0, 0, 0, 0, 0));
    add_word(mk(bfgq_pkg::FN_SET_PEN, 0, 32767, 32767, 0, 0, 0, 0, 0, 0), 1);
    add_word(mk(bfgq_pkg::FN_RENDER, 21'h10FFFF, 0, 0, 0, 0, 0, 0, 0, 0));
    add_word(mk(bfgq_pkg::FN_SET_PEN, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1);
    add_word(mk(bfgq_pkg::FN_RENDER, 77, 0, 0, 0, 0, 0, 0, 0, 0));
    add_word(mk(bfgq_pkg::FN_RENDER, 77, 0, 0, 0, 0, 0, 0, 0, 0));
    add_word(mk(bfgq_pkg::FN_RENDER, 21'h10FFFF, 0, 0, 0, 0, 0, 0, 0, 0));

    foreach (directed_rows[i]) begin
      rw = directed_rows[i];
      if (rw.is_cfg) begin
        s_tvalid <= 1'b0;
        wait_idle();
        write_reg(rw.idx, rw.cval);
      end else send_word(rw.w, rw.typed, rw.res);
    end
    s_tvalid <= 1'b0;

    write_all(100, 50, 2000, 1000, 40, $urandom);
    run_phase(520);
    write_all(32767, 32767, 32767, 32767, 4095, 32'hFFFF_FFFF);
    run_phase(520);
    write_all(0, 0, 0, 0, 0, 32'h0);
    run_phase(340);
    write_all($urandom_range(0, 32767), $urandom_range(0, 2000), $urandom_range(0, 32767),
              $urandom_range(0, 32767), $urandom_range(0, 4095), $urandom);
    run_phase(520);

    while (pending_quads.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // result sink with random stalls and one long hold-off
  initial begin
    bfgq_pkg::res_t got, want;
    string          bad;
    int             gap;
    forever begin
      gap = $urandom_range(0, 15);
      if (quads_seen == 200) gap = 1500;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && !rst));
      quads_seen++;
      got.ql = m_tdata[16:0];
      got.qt = m_tdata[33:17];
      got.qr = m_tdata[50:34];
      got.qb = m_tdata[67:51];
      got.ul = m_tdata[83:68];
      got.vt = m_tdata[99:84];
      got.ur = m_tdata[115:100];
      got.vb = m_tdata[131:116];
      got.page = m_tdata[139:132];
      got.color = m_tdata[171:140];
      got.status = bfgq_pkg::status_t'(m_tuser);
      if (pending_quads.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %p", got);
      end else begin
        want = pending_quads.pop_front();
        bad = "";
        if (got.ql !== want.ql) bad = {bad, " quad_left"};
        if (got.qt !== want.qt) bad = {bad, " quad_top"};
        if (got.qr !== want.qr) bad = {bad, " quad_right"};
        if (got.qb !== want.qb) bad = {bad, " quad_bottom"};
        if (got.ul !== want.ul) bad = {bad, " u_left"};
        if (got.vt !== want.vt) bad = {bad, " v_top"};
        if (got.ur !== want.ur) bad = {bad, " u_right"};
        if (got.vb !== want.vb) bad = {bad, " v_bottom"};
        if (got.page !== want.page) bad = {bad, " page_index"};
        if (got.color !== want.color) bad = {bad, " quad_color"};
        if (got.status !== want.status) bad = {bad, " status"};
        if (bad != "") begin
          errors++;
          if (errors <= 10)
            $display("result %0d bad field(s)%s\n  exp %p\n  got %p",
                     quads_seen, bad, want, got);
        end
      end
    end
  end

  // watchdog
  initial begin
    #50000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
